// ----- rtl/ffpa_pkg.sv -----
package ffpa_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RDB,
    ST_GETB,
    ST_RDN,
    ST_GETN,
    ST_CHECK,
    ST_SPLIT
  } state_t;

  typedef enum logic [1:0] {
    STAT_ALLOC = 2'd0,
    STAT_NOFIT = 2'd1,
    STAT_FREED = 2'd2
  } status_t;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef struct packed {
    logic load;
    logic free_op;
    logic rd_b;
    logic rd_n;
    logic take_b;
    logic skip_b;
    logic absorb;
    logic wr_take;
    logic wr_keep;
    logic wr_second;
    logic done_ok;
    logic done_nofit;
  } cmd_t;

  typedef struct packed {
    logic rd_alloc;
    logic b_fits;
    logic n_fits;
    logic size_ok;
    logic split_ok;
  } dp_stat_t;

endpackage

// ----- rtl/first_fit_pool_allocator_unit.sv -----
// First-fit pool allocator with coalescing of free neighbors.
// Command channel: start with in_op, in_req_size, in_address; a beat is taken
// on a rising edge with start high and busy low.
// Result channel: out_valid is high for exactly one cycle carrying out_status
// and out_address_res; the receiver cannot stall it.
// Free: the result follows in the next cycle; busy stays low, so a new
// command may follow back to back.
// Allocate: the walk reads headers via the single registered read port of
// the header store, skips allocated blocks, merges each free block with the
// free blocks after it and checks the size. A fit marks it allocated and may
// split off the rest as a free block; else the walk goes on, to a no-fit at
// the chain end. The result beat appears in the first cycle with busy low,
// and a new command may be taken in that same cycle.
// Reset is synchronous: the pool becomes one free block at offset 0,
// taking effect at once, with no clearing pass.
module first_fit_pool_allocator_unit #(
  parameter int POOL_UNITS   = 4096,
  parameter int HEADER_UNITS = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_op,
  input  logic [11:0] in_req_size,
  input  logic [11:0] in_address,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [11:0] out_address_res
);
  import ffpa_pkg::*;

  cmd_t     cmd;
  dp_stat_t stat;

  ffpa_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .in_op (in_op),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  ffpa_dp #(
    .POOL_UNITS   (POOL_UNITS),
    .HEADER_UNITS (HEADER_UNITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_req_size     (in_req_size),
    .in_address      (in_address),
    .stat            (stat),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_address_res (out_address_res)
  );

endmodule

// ----- rtl/ffpa_ctrl.sv -----
module ffpa_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              in_op,
  input  ffpa_pkg::dp_stat_t stat,
  output ffpa_pkg::cmd_t     cmd,
  output logic              busy
);
  import ffpa_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (in_op == OP_FREE) begin
            cmd.free_op = 1'b1;
          end else begin
            cmd.load  = 1'b1;
            state_nxt = ST_RDB;
          end
        end
      end
      ST_RDB: begin
        if (stat.b_fits) begin
          cmd.rd_b  = 1'b1;
          state_nxt = ST_GETB;
        end else begin
          cmd.done_nofit = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      ST_GETB: begin
        if (stat.rd_alloc) begin
          cmd.skip_b = 1'b1;
          state_nxt  = ST_RDB;
        end else begin
          cmd.take_b = 1'b1;
          state_nxt  = ST_RDN;
        end
      end
      ST_RDN: begin
        if (stat.n_fits) begin
          cmd.rd_n  = 1'b1;
          state_nxt = ST_GETN;
        end else begin
          state_nxt = ST_CHECK;
        end
      end
      ST_GETN: begin
        if (stat.rd_alloc) begin
          state_nxt = ST_CHECK;
        end else begin
          cmd.absorb = 1'b1;
          state_nxt  = ST_RDN;
        end
      end
      ST_CHECK: begin
        if (stat.size_ok) begin
          cmd.wr_take = 1'b1;
          if (stat.split_ok) begin
            state_nxt = ST_SPLIT;
          end else begin
            cmd.done_ok = 1'b1;
            state_nxt   = ST_IDLE;
          end
        end else begin
          cmd.wr_keep = 1'b1;
          state_nxt   = ST_RDB;
        end
      end
      ST_SPLIT: begin
        cmd.wr_second = 1'b1;
        cmd.done_ok   = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy = (state_r != ST_IDLE);

endmodule

// ----- rtl/ffpa_dp.sv -----
module ffpa_dp #(
  parameter int POOL_UNITS   = 4096,
  parameter int HEADER_UNITS = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ffpa_pkg::cmd_t     cmd,
  input  logic [11:0]        in_req_size,
  input  logic [11:0]        in_address,
  output ffpa_pkg::dp_stat_t stat,
  output logic               out_valid,
  output logic [1:0]         out_status,
  output logic [11:0]        out_address_res
);
  import ffpa_pkg::*;

  localparam int AW = $clog2(POOL_UNITS);
  localparam int SW = AW;
  localparam int OW = ((AW > 12) ? AW : 12) + 2;
  localparam logic [OW-1:0] POOL_C = OW'(POOL_UNITS);
  localparam logic [OW-1:0] HDR_C  = OW'(HEADER_UNITS);
  localparam logic [SW-1:0] SIZE0_C = SW'(POOL_UNITS - HEADER_UNITS);

  logic          alloc_mem [POOL_UNITS];
  logic [SW-1:0] size_mem  [POOL_UNITS];

  logic          a0_valid_r, s0_valid_r;
  logic [OW-1:0] b_r;
  logic [SW-1:0] cur_r;
  logic [11:0]   req_r;
  logic          rd_alloc_r;
  logic [SW-1:0] rd_size_r;
  logic          out_valid_r;
  logic [1:0]    out_status_r;
  logic [11:0]   out_addr_r;

  logic [OW-1:0] n_off, second_off, free_hdr, cur_w, req_w;
  logic          free_hit;
  logic [AW-1:0] rd_addr, wr_addr;
  logic          wr_en_a, wr_en_s, wr_alloc;
  logic [SW-1:0] wr_size;

  assign cur_w      = OW'(cur_r);
  assign req_w      = OW'(req_r);
  assign n_off      = b_r + HDR_C + cur_w;
  assign second_off = b_r + HDR_C + req_w;
  assign free_hdr   = OW'(in_address) - HDR_C;
  assign free_hit   = (in_address != 12'd0) && (OW'(in_address) >= HDR_C) &&
                      (free_hdr < POOL_C);

  assign stat.rd_alloc = rd_alloc_r;
  assign stat.b_fits   = (b_r + HDR_C <= POOL_C);
  assign stat.n_fits   = (n_off + HDR_C <= POOL_C);
  assign stat.size_ok  = (cur_w >= req_w);
  assign stat.split_ok = (req_w + HDR_C <= cur_w) && (second_off + HDR_C <= POOL_C);

  assign rd_addr = cmd.rd_b ? b_r[AW-1:0] : n_off[AW-1:0];

  always_comb begin
    wr_en_a  = 1'b0;
    wr_en_s  = 1'b0;
    wr_addr  = b_r[AW-1:0];
    wr_alloc = 1'b0;
    wr_size  = cur_r;
    if (cmd.free_op) begin
      wr_en_a = free_hit;
      wr_addr = free_hdr[AW-1:0];
    end else if (cmd.wr_take) begin
      wr_en_a  = 1'b1;
      wr_en_s  = 1'b1;
      wr_alloc = 1'b1;
      wr_size  = stat.split_ok ? SW'(req_r) : cur_r;
    end else if (cmd.wr_keep) begin
      wr_en_a = 1'b1;
      wr_en_s = 1'b1;
    end else if (cmd.wr_second) begin
      wr_en_a = 1'b1;
      wr_en_s = 1'b1;
      wr_addr = second_off[AW-1:0];
      wr_size = SW'(cur_w - req_w - HDR_C);
    end
  end

  // header store; entry 0 reads as the initial free block until written
  always_ff @(posedge clk) begin
    if (wr_en_a) begin
      alloc_mem[wr_addr] <= wr_alloc;
    end
    if (wr_en_s) begin
      size_mem[wr_addr] <= wr_size;
    end
    if (cmd.rd_b || cmd.rd_n) begin
      rd_alloc_r <= (rd_addr == '0 && !a0_valid_r) ? 1'b0 : alloc_mem[rd_addr];
      rd_size_r  <= (rd_addr == '0 && !s0_valid_r) ? SIZE0_C : size_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a0_valid_r  <= 1'b0;
      s0_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (wr_en_a && wr_addr == '0) begin
        a0_valid_r <= 1'b1;
      end
      if (wr_en_s && wr_addr == '0) begin
        s0_valid_r <= 1'b1;
      end
      out_valid_r <= cmd.free_op || cmd.done_ok || cmd.done_nofit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      b_r   <= '0;
      req_r <= in_req_size;
    end else if (cmd.skip_b) begin
      b_r <= b_r + HDR_C + OW'(rd_size_r);
    end else if (cmd.wr_keep) begin
      b_r <= n_off;
    end
    if (cmd.take_b) begin
      cur_r <= rd_size_r;
    end else if (cmd.absorb) begin
      cur_r <= SW'(cur_w + OW'(rd_size_r) + HDR_C);
    end
    if (cmd.free_op) begin
      out_status_r <= STAT_FREED;
      out_addr_r   <= 12'd0;
    end else if (cmd.done_nofit) begin
      out_status_r <= STAT_NOFIT;
      out_addr_r   <= 12'd0;
    end else if (cmd.done_ok) begin
      out_status_r <= STAT_ALLOC;
      out_addr_r   <= 12'((b_r + HDR_C) & OW'(12'hFFF));
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_address_res = out_addr_r;

endmodule

// ----- rtl/ffpa_checker.sv -----
module ffpa_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        in_op,
  input logic        out_valid,
  input logic [1:0]  out_status,
  input logic [11:0] out_address_res
);
  import ffpa_pkg::*;

  a_free_result: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_op == OP_FREE |=> out_valid && out_status == STAT_FREED)
    else $error("free beat without free result");

  a_alloc_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_op == OP_ALLOC |=> busy && !out_valid)
    else $error("allocate beat did not start a walk");

  a_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != STAT_ALLOC |-> out_address_res == 12'd0)
    else $error("nonzero address on non-allocate result");

  a_alloc_after_walk: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == STAT_ALLOC || out_status == STAT_NOFIT) |->
      $past(busy) && !busy)
    else $error("allocate result not at end of walk");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status != 2'd3)
    else $error("undefined status code");

endmodule

bind first_fit_pool_allocator_unit ffpa_checker u_ffpa_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .in_op           (in_op),
  .out_valid       (out_valid),
  .out_status      (out_status),
  .out_address_res (out_address_res)
);
